[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The condition must never be true outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[hdl/adtsp_pkg.sv]
// ----------------------------------------------------------------------------
// ADTS parser package
// Types, constants and the sampling rate table shared by the parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package adtsp_pkg;

  localparam int COUNT_BITS_DEFAULT = 16;

  localparam int BYTE_W   = 8;
  localparam int FNUM_W   = 16;
  localparam int PROF_W   = 2;
  localparam int RIDX_W   = 4;
  localparam int RATE_W   = 17;
  localparam int LEN_W    = 13;

  localparam logic [BYTE_W-1:0] SYNC_BYTE   = 8'hFF;
  localparam logic [3:0]        SYNC_NIBBLE = 4'hF;
  localparam logic [LEN_W-1:0]  MIN_LENGTH  = 13'd7;

  // Header byte positions within a frame
  localparam logic [LEN_W-1:0] POS_AFTER_SYNC = 13'd2;
  localparam logic [LEN_W-1:0] POS_LEN_HIGH   = 13'd3;
  localparam logic [LEN_W-1:0] POS_LEN_MID    = 13'd4;
  localparam logic [LEN_W-1:0] POS_LEN_LOW    = 13'd5;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    PH_HUNT  = 3'b001,
    PH_SYNC2 = 3'b010,
    PH_FRAME = 3'b100
  } phase_t;

  typedef struct packed {
    logic [FNUM_W-1:0] frame_number;
    logic [PROF_W-1:0] profile;
    logic [RIDX_W-1:0] rate_index;
    logic [LEN_W-1:0]  frame_length;
  } report_t;

  function automatic logic [RATE_W-1:0] rate_hz(input logic [RIDX_W-1:0] idx);
    logic [RATE_W-1:0] r;
    case (idx)
      4'd0:    r = 17'd96000;
      4'd1:    r = 17'd88200;
      4'd2:    r = 17'd64000;
      4'd3:    r = 17'd48000;
      4'd4:    r = 17'd44100;
      4'd5:    r = 17'd32000;
      4'd6:    r = 17'd24000;
      4'd7:    r = 17'd22050;
      4'd8:    r = 17'd16000;
      4'd9:    r = 17'd12000;
      4'd10:   r = 17'd11025;
      4'd11:   r = 17'd8000;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[hdl/adts_frame_header_parser_core.sv]
// ----------------------------------------------------------------------------
// ADTS frame header parser
// Finds ADTS frames in a byte stream and reports each frame's header fields,
// sampling rate and length on the frame's last byte.
// ----------------------------------------------------------------------------
//  Channel | Handshake            | Word
//  --------+----------------------+----------------------------------------
//  input   | in_valid / in_ready  | stream_byte
//  output  | out_valid / out_ready| frame_number, profile, rate_index,
//          |                      | sample_rate_hz, frame_length
//
//  One byte is taken per cycle unless the queue is full; its report, if any,
//  passes through the report queue and appears in the cycle after the pop.
//  The byte input stalls only when the four-word report queue is full.
//  rst is synchronous: it returns the parser to hunting for sync and empties
//  the queue and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adts_frame_header_parser_core #(
  parameter int COUNT_BITS = adtsp_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [adtsp_pkg::BYTE_W-1:0] stream_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [adtsp_pkg::FNUM_W-1:0] frame_number,
  output logic [adtsp_pkg::PROF_W-1:0] profile,
  output logic [adtsp_pkg::RIDX_W-1:0] rate_index,
  output logic [adtsp_pkg::RATE_W-1:0] sample_rate_hz,
  output logic [adtsp_pkg::LEN_W-1:0]  frame_length
);
  import adtsp_pkg::*;

  logic    q_full;
  logic    q_nonempty;
  logic    push;
  logic    pop;
  report_t push_data;
  report_t pop_data;

  adtsp_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .stream_byte (stream_byte),
    .q_full      (q_full),
    .push        (push),
    .push_data   (push_data)
  );

  adtsp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .nonempty  (q_nonempty),
    .pop_data  (pop_data)
  );

  adtsp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_nonempty     (q_nonempty),
    .q_data         (pop_data),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frame_number   (frame_number),
    .profile        (profile),
    .rate_index     (rate_index),
    .sample_rate_hz (sample_rate_hz),
    .frame_length   (frame_length)
  );

endmodule

[hdl/adtsp_front.sv]
// ----------------------------------------------------------------------------
// ADTS parser front end
// Hunts for sync, captures header fields, counts frame bytes and raises a
// report word on the last byte of each frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module adtsp_front #(
  parameter int COUNT_BITS = adtsp_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [adtsp_pkg::BYTE_W-1:0]  stream_byte,
  input  logic                          q_full,
  output logic                          push,
  output adtsp_pkg::report_t            push_data
);
  import adtsp_pkg::*;

  phase_t              phase, phase_next;
  logic [LEN_W-1:0]    pos, pos_next;
  logic [PROF_W-1:0]   held_profile, held_profile_next;
  logic [RIDX_W-1:0]   held_rate_index, held_rate_index_next;
  logic [LEN_W-1:0]    held_length, held_length_next;
  logic [COUNT_BITS-1:0] frame_counter;
  logic                accept;
  logic                report;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    phase_next           = phase;
    pos_next             = pos;
    held_profile_next    = held_profile;
    held_rate_index_next = held_rate_index;
    held_length_next     = held_length;
    report               = 1'b0;
    unique case (phase)
      PH_SYNC2: begin
        if (stream_byte[7:4] == SYNC_NIBBLE) begin
          phase_next = PH_FRAME;
          pos_next   = POS_AFTER_SYNC;
        end else if (stream_byte != SYNC_BYTE) begin
          phase_next = PH_HUNT;
        end
      end
      PH_FRAME: begin
        case (pos)
          POS_AFTER_SYNC: begin
            held_profile_next    = stream_byte[7:6];
            held_rate_index_next = stream_byte[5:2];
          end
          POS_LEN_HIGH: held_length_next = {stream_byte[1:0], 11'd0};
          POS_LEN_MID:  held_length_next = held_length | {2'd0, stream_byte, 3'd0};
          POS_LEN_LOW:  held_length_next = held_length | {10'd0, stream_byte[7:5]};
          default:      held_length_next = held_length;
        endcase
        // A length below the header size is rejected: the frame
        // is dropped once its length is complete.
        if (pos == POS_LEN_LOW && held_length_next < MIN_LENGTH) begin
          phase_next = PH_HUNT;
          pos_next   = '0;
        end else if (pos >= POS_LEN_LOW &&
                     ({1'b0, pos} + 14'd1) == {1'b0, held_length_next}) begin
          report     = 1'b1;
          phase_next = PH_HUNT;
          pos_next   = '0;
        end else begin
          pos_next = pos + 13'd1;
        end
      end
      default: begin
        phase_next = (stream_byte == SYNC_BYTE) ? PH_SYNC2 : PH_HUNT;
        pos_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      pos             <= '0;
      held_profile    <= '0;
      held_rate_index <= '0;
      held_length     <= '0;
      frame_counter   <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      pos             <= pos_next;
      held_profile    <= held_profile_next;
      held_rate_index <= held_rate_index_next;
      held_length     <= held_length_next;
      if (report) begin
        frame_counter <= frame_counter + 1'b1;
      end
    end
  end

  assign push                   = accept && report;
  assign push_data.frame_number = FNUM_W'(frame_counter);
  assign push_data.profile      = held_profile;
  assign push_data.rate_index   = held_rate_index;
  assign push_data.frame_length = held_length_next;

  `ASSERT_CLK(a_pos_clear_outside_frame, (phase != PH_FRAME) |-> (pos == '0),
              "byte position not cleared outside a frame")

endmodule

[hdl/adtsp_fifo.sv]
// ----------------------------------------------------------------------------
// ADTS parser report queue
// Short first-in first-out queue of report words between front and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module adtsp_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  adtsp_pkg::report_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               nonempty,
  output adtsp_pkg::report_t pop_data
);
  import adtsp_pkg::*;

  report_t             mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full     = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `ASSERT_NEVER(a_no_overflow, push && full && !pop,
                "report word pushed into a full queue")
  `ASSERT_NEVER(a_no_underflow, pop && !nonempty,
                "report word popped from an empty queue")

endmodule

[hdl/adtsp_back.sv]
// ----------------------------------------------------------------------------
// ADTS parser back end
// Takes report words from the queue, decodes the sampling rate and holds the
// result in the output register until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module adtsp_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_nonempty,
  input  adtsp_pkg::report_t           q_data,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [adtsp_pkg::FNUM_W-1:0] frame_number,
  output logic [adtsp_pkg::PROF_W-1:0] profile,
  output logic [adtsp_pkg::RIDX_W-1:0] rate_index,
  output logic [adtsp_pkg::RATE_W-1:0] sample_rate_hz,
  output logic [adtsp_pkg::LEN_W-1:0]  frame_length
);
  import adtsp_pkg::*;

  assign pop = q_nonempty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      frame_number   <= q_data.frame_number;
      profile        <= q_data.profile;
      rate_index     <= q_data.rate_index;
      sample_rate_hz <= rate_hz(q_data.rate_index);
      frame_length   <= q_data.frame_length;
    end
  end

  `ASSERT_CLK(a_pop_loads_output, pop |=> out_valid,
              "output register not loaded after a queue pop")

endmodule
